/* hdl/lfqm_pkg.sv */
// ----------------------------------------------------------------------------
// Linked FIFO queue manager package
// Shared constants, operation codes and the command and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lfqm_pkg;

    // Handle and count widths are fixed by the word format.
    localparam int unsigned HANDLE_W     = 6;
    localparam int unsigned COUNT_W      = 7;
    localparam int unsigned HANDLE_SPACE = 64;

    // Largest number of elements the queue may hold. Handles at or above this
    // value are refused by enqueue.
    localparam int unsigned MAX_ELEMENTS = 64;

    // Effective capacity is bounded by the handle space as well.
    localparam int unsigned CAPACITY_INT =
        (MAX_ELEMENTS < HANDLE_SPACE) ? MAX_ELEMENTS : HANDLE_SPACE;
    localparam logic [COUNT_W-1:0] CAPACITY  = COUNT_W'(CAPACITY_INT);
    localparam logic [12:0]        MAX_ELEM_W = 13'(MAX_ELEMENTS);

    // Operation codes carried by the input word.
    typedef enum logic [1:0] {
        OP_ENQ    = 2'd0,
        OP_DEQ    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch a new input word and reset the walk
        logic advance;    // step the remove walk to the next link
        logic commit;     // apply the operation and load the output word
        logic rd_en;      // enable the link table read port
        logic rd_follow;  // read at the last link read instead of the head
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_more;  // remove walk has not found the handle and has links left
    } t_dp_status;

endpackage

`default_nettype wire

/* hdl/linked_fifo_queue_manager_unit.sv */
// ----------------------------------------------------------------------------
// Linked FIFO queue manager
// A FIFO of element handles kept as a singly linked list in a next-link
// table, with enqueue, dequeue, peek and remove-by-handle operations.
//
// Input channel: i_in_valid, o_in_stall, word fields i_operation and i_elem.
// Output channel: o_out_valid, i_out_stall, word fields o_out_elem, o_ok,
// o_empty_res and o_elem_count. A word moves at a clock edge where valid is
// high and stall is low.
// One word is processed at a time. After acceptance, enqueue, dequeue and
// peek pass through the work state, where the result is loaded into the
// output register once it is free, and the block then returns to idle for
// the next word. Remove stays in the work state while the walk follows one
// link per cycle through the table's single read port, up to the handle or
// the last link when it is not found, and then loads its result likewise.
// Reset empties the queue at once; link table contents are left as they are
// and no value from an entry is used before that entry is written. When the
// receiver stalls, the output word holds and one more word may be accepted
// and worked on; it then waits until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_fifo_queue_manager_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_operation,
    input  wire logic [lfqm_pkg::HANDLE_W-1:0] i_elem,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [lfqm_pkg::HANDLE_W-1:0]      o_out_elem,
    output logic                               o_ok,
    output logic                               o_empty_res,
    output logic [lfqm_pkg::COUNT_W-1:0]       o_elem_count
);
    import lfqm_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer.
    lfqm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Queue state, link table and output word.
    lfqm_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_operation  (i_operation),
        .i_elem       (i_elem),
        .o_out_elem   (o_out_elem),
        .o_ok         (o_ok),
        .o_empty_res  (o_empty_res),
        .o_elem_count (o_elem_count)
    );

    // A reported count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_elem_count <= CAPACITY))
        else $error("element count above capacity");

    // The empty flag agrees with the count.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_empty_res == (o_elem_count == '0)))
        else $error("empty flag disagrees with count");

    // Only one word is in progress: an accepted word blocks the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second word accepted while one is in progress");

    // A new output word appears only after a word was taken in.
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("output word without a word in progress");

endmodule

`default_nettype wire

/* hdl/lfqm_ctrl.sv */
// ----------------------------------------------------------------------------
// Linked FIFO queue manager controller
// Two-state sequencer that takes one word at a time, runs the remove walk
// and owns the output word valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lfqm_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    input  lfqm_pkg::t_dp_status      i_status,
    output lfqm_pkg::t_dp_cmd         o_cmd
);
    import lfqm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    w_out_free;
    t_dp_cmd w_cmd;

    // The output register can take a new word when empty or being drained.
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Next state and datapath commands.
    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                // Keep the head link prefetched so dequeue and the walk start at once.
                w_cmd.rd_en   = 1'b1;
                w_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_WORK;
                end
            end
            S_WORK: begin
                w_cmd.rd_follow = 1'b1;
                if (i_status.walk_more) begin
                    w_cmd.advance = 1'b1;
                    w_cmd.rd_en   = 1'b1;
                end else if (w_out_free) begin
                    w_cmd.commit = 1'b1;
                    w_cmd.rd_en  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output word valid flag.
    assign n_out_valid = w_cmd.commit || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

`default_nettype wire

/* hdl/lfqm_datapath.sv */
// ----------------------------------------------------------------------------
// Linked FIFO queue manager datapath
// Head, tail and count registers, the next-link table, the remove walk
// registers and the output word registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lfqm_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  lfqm_pkg::t_dp_cmd                  i_cmd,
    output lfqm_pkg::t_dp_status               o_status,
    input  wire logic [1:0]                    i_operation,
    input  wire logic [lfqm_pkg::HANDLE_W-1:0] i_elem,
    output logic [lfqm_pkg::HANDLE_W-1:0]      o_out_elem,
    output logic                               o_ok,
    output logic                               o_empty_res,
    output logic [lfqm_pkg::COUNT_W-1:0]       o_elem_count
);
    import lfqm_pkg::*;

    // Queue state.
    logic [HANDLE_W-1:0] r_head;
    logic [HANDLE_W-1:0] r_tail;
    logic [COUNT_W-1:0]  r_count;
    logic [HANDLE_W-1:0] n_head;
    logic [HANDLE_W-1:0] n_tail;
    logic [COUNT_W-1:0]  n_count;

    // Latched input word and walk registers.
    t_op                 r_op;
    logic [HANDLE_W-1:0] r_elem;
    logic [HANDLE_W-1:0] r_cur;
    logic [HANDLE_W-1:0] r_prev;
    logic                r_has_prev;
    logic [HANDLE_W-1:0] r_idx;

    // Link table.
    logic [HANDLE_W-1:0] r_link [HANDLE_SPACE];
    logic [HANDLE_W-1:0] r_rd_data;
    logic [HANDLE_W-1:0] w_raddr;
    logic                w_we;
    logic [HANDLE_W-1:0] w_waddr;
    logic [HANDLE_W-1:0] w_wdata;

    // Output word.
    logic [HANDLE_W-1:0] r_out_elem;
    logic                r_out_ok;
    logic                r_out_empty;
    logic [COUNT_W-1:0]  r_out_count;
    logic [HANDLE_W-1:0] w_res_elem;
    logic                w_res_ok;

    // Decoded conditions.
    logic                w_count_nz;
    logic                w_match;
    logic                w_is_last;
    logic                w_enq_ok;
    logic [HANDLE_W-1:0] w_succ;

    assign w_count_nz = (r_count != '0);
    assign w_match    = w_count_nz && (r_cur == r_elem);
    assign w_is_last  = ({1'b0, r_idx} + COUNT_W'(1)) == r_count;
    assign w_enq_ok   = ({7'b0, r_elem} < MAX_ELEM_W) && (r_count < CAPACITY);
    assign w_succ     = w_is_last ? '0 : r_rd_data;

    assign o_status.walk_more = (r_op == OP_REMOVE) && w_count_nz && !w_match && !w_is_last;

    // Next queue state and result of the current operation.
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        w_we       = 1'b0;
        w_waddr    = r_tail;
        w_wdata    = r_elem;
        w_res_elem = r_elem;
        w_res_ok   = 1'b0;
        unique case (r_op) inside
            OP_ENQ: begin
                if (w_enq_ok) begin
                    w_res_ok = 1'b1;
                    if (!w_count_nz) begin
                        n_head = r_elem;
                    end else begin
                        w_we = 1'b1;
                    end
                    n_tail  = r_elem;
                    n_count = r_count + COUNT_W'(1);
                end
            end
            OP_DEQ, OP_PEEK: begin
                if (w_count_nz) begin
                    w_res_elem = r_head;
                    w_res_ok   = 1'b1;
                    if (r_op == OP_DEQ) begin
                        // The head link was read while idle.
                        n_count = r_count - COUNT_W'(1);
                        n_head  = r_rd_data;
                    end
                end else begin
                    w_res_elem = '0;
                end
            end
            OP_REMOVE: begin
                if (w_match) begin
                    w_res_ok = 1'b1;
                    if (r_has_prev) begin
                        // Bridge the predecessor over the removed handle.
                        if (!w_is_last) begin
                            w_we    = 1'b1;
                            w_waddr = r_prev;
                            w_wdata = w_succ;
                        end
                    end else begin
                        n_head = w_succ;
                    end
                    if (w_is_last) begin
                        n_tail = r_prev;
                    end
                    n_count = r_count - COUNT_W'(1);
                end
            end
            default: begin
                w_res_ok = 1'b0;
            end
        endcase
        // An empty queue parks both ends at zero.
        if (n_count == '0) begin
            n_head = '0;
            n_tail = '0;
        end
    end

    // Read address follows the last link read during the walk.
    assign w_raddr = i_cmd.rd_follow ? r_rd_data : r_head;

    // Link table with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_we) begin
            r_link[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_link[w_raddr];
        end
    end

    // Queue state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Input word capture and walk stepping.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= t_op'(i_operation);
            r_elem     <= i_elem;
            r_cur      <= r_head;
            r_prev     <= '0;
            r_has_prev <= 1'b0;
            r_idx      <= '0;
        end else if (i_cmd.advance) begin
            r_prev     <= r_cur;
            r_has_prev <= 1'b1;
            r_cur      <= r_rd_data;
            r_idx      <= r_idx + HANDLE_W'(1);
        end
    end

    // Output word registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_elem  <= w_res_elem;
            r_out_ok    <= w_res_ok;
            r_out_empty <= (n_count == '0);
            r_out_count <= n_count;
        end
    end

    assign o_out_elem   = r_out_elem;
    assign o_ok         = r_out_ok;
    assign o_empty_res  = r_out_empty;
    assign o_elem_count = r_out_count;

endmodule

`default_nettype wire

/* tb/tb_linked_fifo_queue_manager_unit.sv */
// ----------------------------------------------------------------------------
// Linked FIFO queue manager testbench
// Drives enqueue, dequeue, peek and remove words into the queue manager and
// checks every output word against a shadow copy of the linked list. A
// short table of directed words comes first. It is followed by random
// traffic that fills the queue to capacity and drains it to empty several
// times. The sender idles in bursts and the receiver stalls in segments of
// its own, one of them long enough to back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_linked_fifo_queue_manager_unit;

    import lfqm_pkg::*;

    localparam int RANDOM_WORDS = 600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;

    // One output word as the block reports it.
    typedef struct packed {
        logic [HANDLE_W-1:0] elem;
        logic                ok;
        logic                empty;
        logic [COUNT_W-1:0]  count;
    } t_qm_word;

    // One row of the directed table; the typed word is used when fixed is set.
    typedef struct packed {
        t_op                 op;
        logic [HANDLE_W-1:0] elem;
        logic                fixed;
        t_qm_word            want;
    } t_dir_row;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_PATTERN,
        RX_HOLD
    } t_rx_style;

    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{OP_PEEK,   6'd0,  1'b1, '{6'd0,  1'b0, 1'b1, 7'd0}},
        '{OP_DEQ,    6'd63, 1'b1, '{6'd0,  1'b0, 1'b1, 7'd0}},
        '{OP_REMOVE, 6'd63, 1'b1, '{6'd63, 1'b0, 1'b1, 7'd0}},
        '{OP_ENQ,    6'd0,  1'b1, '{6'd0,  1'b1, 1'b0, 7'd1}},
        '{OP_ENQ,    6'd63, 1'b1, '{6'd63, 1'b1, 1'b0, 7'd2}},
        '{OP_PEEK,   6'd21, 1'b1, '{6'd0,  1'b1, 1'b0, 7'd2}},
        '{OP_ENQ,    6'd42, 1'b0, '0},
        '{OP_REMOVE, 6'd63, 1'b0, '0},
        '{OP_REMOVE, 6'd42, 1'b0, '0},
        '{OP_ENQ,    6'd7,  1'b0, '0},
        '{OP_ENQ,    6'd56, 1'b0, '0},
        '{OP_REMOVE, 6'd0,  1'b0, '0},
        '{OP_REMOVE, 6'd0,  1'b0, '0},
        '{OP_DEQ,    6'd45, 1'b0, '0},
        '{OP_PEEK,   6'd18, 1'b0, '0},
        '{OP_REMOVE, 6'd56, 1'b1, '{6'd56, 1'b1, 1'b1, 7'd0}},
        '{OP_ENQ,    6'd21, 1'b1, '{6'd21, 1'b1, 1'b0, 7'd1}},
        '{OP_DEQ,    6'd0,  1'b1, '{6'd21, 1'b1, 1'b1, 7'd0}},
        '{OP_ENQ,    6'd1,  1'b0, '0},
        '{OP_ENQ,    6'd2,  1'b0, '0},
        '{OP_REMOVE, 6'd2,  1'b0, '0},
        '{OP_ENQ,    6'd8,  1'b0, '0},
        '{OP_DEQ,    6'd33, 1'b0, '0},
        '{OP_DEQ,    6'd12, 1'b0, '0},
        '{OP_DEQ,    6'd63, 1'b1, '{6'd0,  1'b0, 1'b1, 7'd0}}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [1:0]          i_operation;
    logic [HANDLE_W-1:0] i_elem;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [HANDLE_W-1:0] o_out_elem;
    logic                o_ok;
    logic                o_empty_res;
    logic [COUNT_W-1:0]  o_elem_count;

    // Shadow copy of the linked list.
    logic [HANDLE_W-1:0] shadow_head;
    logic [HANDLE_W-1:0] shadow_tail;
    logic [COUNT_W-1:0]  shadow_count;
    logic [HANDLE_W-1:0] shadow_link [HANDLE_SPACE];
    bit                  shadow_queued [HANDLE_SPACE];

    t_qm_word due_words [$];
    int       mismatch_count;
    int       cycle_count;
    int       burst_left;

    linked_fifo_queue_manager_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_elem       (i_elem),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_elem   (o_out_elem),
        .o_ok         (o_ok),
        .o_empty_res  (o_empty_res),
        .o_elem_count (o_elem_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Print one line per mismatch and count it.
    task automatic note_mismatch(input string field, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // Apply one operation to the shadow list and return the word it produces.
    function automatic t_qm_word apply_queue_op(input t_op op, input logic [HANDLE_W-1:0] h);
        t_qm_word            w;
        logic [HANDLE_W-1:0] cur;
        logic [HANDLE_W-1:0] prev;
        logic [HANDLE_W-1:0] succ;
        bit                  has_prev;
        bit                  last;
        int                  i;

        w = '0;
        case (op)
            OP_ENQ: begin
                w.elem = h;
                if (int'(h) < int'(MAX_ELEMENTS) && shadow_count < CAPACITY) begin
                    if (shadow_count == 0) begin
                        shadow_head = h;
                    end else begin
                        shadow_link[shadow_tail] = h;
                    end
                    shadow_tail = h;
                    shadow_count++;
                    shadow_queued[h] = 1'b1;
                    w.ok = 1'b1;
                end
            end
            OP_DEQ, OP_PEEK: begin
                if (shadow_count != 0) begin
                    w.elem = shadow_head;
                    w.ok = 1'b1;
                    if (op == OP_DEQ) begin
                        shadow_queued[shadow_head] = 1'b0;
                        shadow_count--;
                        if (shadow_count != 0) begin
                            shadow_head = shadow_link[shadow_head];
                        end
                    end
                end
            end
            default: begin
                // Walk from the head, remembering the previous link to splice around.
                w.elem = h;
                cur = shadow_head;
                prev = '0;
                has_prev = 1'b0;
                for (i = 0; i < int'(shadow_count) && !w.ok; i++) begin
                    if (cur == h) begin
                        last = (i + 1 == int'(shadow_count));
                        succ = last ? '0 : shadow_link[cur];
                        if (has_prev) begin
                            if (!last) begin
                                shadow_link[prev] = succ;
                            end
                        end else begin
                            shadow_head = succ;
                        end
                        if (last) begin
                            shadow_tail = prev;
                        end
                        shadow_count--;
                        shadow_queued[h] = 1'b0;
                        w.ok = 1'b1;
                    end else if (i + 1 < int'(shadow_count)) begin
                        prev = cur;
                        has_prev = 1'b1;
                        cur = shadow_link[cur];
                    end
                end
            end
        endcase
        // An emptied queue parks both ends at handle zero.
        if (shadow_count == 0) begin
            shadow_head = '0;
            shadow_tail = '0;
        end
        w.empty = (shadow_count == 0);
        w.count = shadow_count;
        return w;
    endfunction

    // Offer one word, holding it until accepted, and record what it should produce.
    task automatic send_word(input t_op op, input logic [HANDLE_W-1:0] h,
                             input bit fixed, input t_qm_word want);
        t_qm_word predicted;
        int       gap;

        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                @(negedge i_clk) i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_elem      <= h;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = apply_queue_op(op, h);
        due_words.push_back(fixed ? want : predicted);
    endtask

    // Random traffic that alternates between filling and draining the queue.
    task automatic send_random_words(input int n);
        t_op                 op;
        logic [HANDLE_W-1:0] h;
        bit                  filling;
        int                  r;
        int                  k;
        int                  steps;

        filling = 1'b1;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (filling && shadow_count == CAPACITY) begin
                // Enqueue into a full queue must be refused; then start draining.
                op = OP_ENQ;
                filling = 1'b0;
            end else if (!filling && shadow_count == 0) begin
                op = (r < 50) ? OP_DEQ : OP_PEEK;
                filling = 1'b1;
            end else begin
                if ($urandom_range(0, 99) == 0) begin
                    filling = !filling;
                end
                if (filling) begin
                    op = (r < 65) ? OP_ENQ : (r < 78) ? OP_DEQ : (r < 88) ? OP_PEEK : OP_REMOVE;
                end else begin
                    op = (r < 15) ? OP_ENQ : (r < 65) ? OP_DEQ : (r < 78) ? OP_PEEK : OP_REMOVE;
                end
            end

            h = HANDLE_W'($urandom_range(0, HANDLE_SPACE - 1));
            if (op == OP_ENQ && shadow_count < CAPACITY) begin
                // Never enqueue a handle that is already in the queue.
                while (shadow_queued[h]) h = HANDLE_W'($urandom_range(0, HANDLE_SPACE - 1));
            end else if (op == OP_REMOVE && shadow_count != 0 && $urandom_range(0, 3) != 0) begin
                steps = $urandom_range(0, int'(shadow_count) - 1);
                h = shadow_head;
                repeat (steps) h = shadow_link[h];
            end
            send_word(op, h, 1'b0, '0);
        end
    endtask

    // Receiver stall segments, with one long hold-off to back up the block.
    initial begin : out_stall_gen
        t_rx_style  style;
        int         seg_left;
        int         rx_cycles;
        bit         hold_done;
        logic [7:0] pat;

        i_out_stall = 1'b0;
        style = RX_FREE;
        seg_left = 0;
        rx_cycles = 0;
        hold_done = 1'b0;
        pat = '0;
        forever begin
            @(negedge i_clk);
            rx_cycles++;
            if (seg_left == 0) begin
                if (!hold_done && rx_cycles > 600) begin
                    style = RX_HOLD;
                    seg_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end else begin
                    style = t_rx_style'($urandom_range(0, 2));
                    seg_left = $urandom_range(10, 80);
                    pat = 8'($urandom);
                end
            end
            seg_left--;
            case (style)
                RX_FREE:    i_out_stall <= 1'b0;
                RX_RANDOM:  i_out_stall <= ($urandom_range(0, 2) == 0);
                RX_PATTERN: i_out_stall <= pat[rx_cycles % 8];
                default:    i_out_stall <= 1'b1;
            endcase
        end
    end

    // Compare each accepted output word with the oldest expected word.
    always @(posedge i_clk) begin : result_check
        t_qm_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_words.size() == 0) begin
                note_mismatch("unexpected word, out_elem", int'(o_out_elem), 0);
            end else begin
                want = due_words.pop_front();
                if (o_out_elem !== want.elem) begin
                    note_mismatch("out_elem", int'(o_out_elem), int'(want.elem));
                end
                if (o_ok !== want.ok) begin
                    note_mismatch("ok", int'(o_ok), int'(want.ok));
                end
                if (o_empty_res !== want.empty) begin
                    note_mismatch("empty_res", int'(o_empty_res), int'(want.empty));
                end
                if (o_elem_count !== want.count) begin
                    note_mismatch("elem_count", int'(o_elem_count), int'(want.count));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : main_seq
        int k;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_operation = OP_ENQ;
        i_elem = '0;
        mismatch_count = 0;
        cycle_count = 0;
        burst_left = 0;
        shadow_head = '0;
        shadow_tail = '0;
        shadow_count = '0;
        for (k = 0; k < int'(HANDLE_SPACE); k++) begin
            shadow_link[k] = '0;
            shadow_queued[k] = 1'b0;
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++) begin
            send_word(DIRECTED[k].op, DIRECTED[k].elem, DIRECTED[k].fixed, DIRECTED[k].want);
        end
        send_random_words(RANDOM_WORDS);

        @(negedge i_clk) i_in_valid <= 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* linked_fifo_queue_manager_unit.f */
hdl/lfqm_pkg.sv
hdl/lfqm_ctrl.sv
hdl/lfqm_datapath.sv
hdl/linked_fifo_queue_manager_unit.sv
tb/tb_linked_fifo_queue_manager_unit.sv
